### rtl/wfac_pkg.sv
// Package for the waterfall average colormap block: sizes, line geometry
// and the sine-shaped palette ROM. No dependencies.
package wfac_pkg;

	// Line geometry and stores
	localparam int LINE_BINS   = 1024;
	localparam int STORE_DEPTH = 1024;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);
	localparam int IDX_W       = 10;
	localparam int COL_W       = 10;
	localparam int LEVEL_W     = 8;
	localparam int CHAN_W      = 8;
	localparam int HIST_W      = 3 * LEVEL_W;
	localparam int LINE_W      = $clog2(LINE_BINS) + 1;
	localparam int HALF_ROT    = LINE_BINS - LINE_BINS / 2;

	// Palette constants
	localparam logic [LEVEL_W-1:0] PAL_PERIOD   = 8'd170;
	localparam logic [LEVEL_W-1:0] PAL_HALF     = 8'd85;
	localparam logic [LEVEL_W-1:0] RED_OFFSET   = 8'd170;
	localparam logic [LEVEL_W-1:0] GREEN_OFFSET = 8'd60;
	localparam logic [LEVEL_W-1:0] BLUE_OFFSET  = 8'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_CLAMP  = 8'd254;

	// Configuration register map (word index)
	localparam logic REG_CENTER = 1'b0;

	// floor(255*sin(pi*n/170)) for n = 0..85
	localparam logic [CHAN_W-1:0] HALF_SINE [86] = '{
		8'd0,   8'd4,   8'd9,   8'd14,  8'd18,  8'd23,  8'd28,  8'd32,  8'd37,  8'd42,
		8'd46,  8'd51,  8'd56,  8'd60,  8'd65,  8'd69,  8'd74,  8'd78,  8'd83,  8'd87,
		8'd92,  8'd96,  8'd100, 8'd105, 8'd109, 8'd113, 8'd117, 8'd122, 8'd126, 8'd130,
		8'd134, 8'd138, 8'd142, 8'd146, 8'd149, 8'd153, 8'd157, 8'd161, 8'd164, 8'd168,
		8'd171, 8'd175, 8'd178, 8'd181, 8'd185, 8'd188, 8'd191, 8'd194, 8'd197, 8'd200,
		8'd203, 8'd206, 8'd209, 8'd211, 8'd214, 8'd216, 8'd219, 8'd221, 8'd223, 8'd226,
		8'd228, 8'd230, 8'd232, 8'd234, 8'd236, 8'd237, 8'd239, 8'd241, 8'd242, 8'd243,
		8'd245, 8'd246, 8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd252, 8'd252, 8'd253,
		8'd253, 8'd254, 8'd254, 8'd254, 8'd254, 8'd255
	};

	// Full sine arch: zero outside 1..169, mirrored around 85
	function automatic logic [CHAN_W-1:0] sine_lut(input logic [LEVEL_W-1:0] n);
		logic [LEVEL_W-1:0] m;
		m = (n > PAL_HALF) ? (PAL_PERIOD - n) : n;
		if (n == '0 || n >= PAL_PERIOD) begin
			return '0;
		end
		return HALF_SINE[m[6:0]];
	endfunction

	// One palette channel: sine arch shifted right by offset
	function automatic logic [CHAN_W-1:0] pal_chan(input logic [LEVEL_W-1:0] avg,
			input logic [LEVEL_W-1:0] offset);
		if (avg <= offset) begin
			return '0;
		end
		return sine_lut(avg - offset);
	endfunction

endpackage

### rtl/wfac_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read at the written address in the same cycle returns the old data.
module wfac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/waterfall_average_colormap.sv
// Top level of the waterfall average colormap block.
// Depends on wfac_pkg and the wfac_ram line-history memory.

// One bin beat can be taken per clock while bin_stall is low. A taken bin
// waits in stage 1 while its column history is read, and its colored pixel
// is loaded into the output register when stage 1 advances. The history RAM
// has separate read and write ports: it is read when a bin is taken and
// written back when that beat moves on to the output register, with a bypass
// covering back-to-back beats on the same column. A stalled pixel holds
// stage 1 and raises bin_stall. After reset the block zeroes the history RAM
// of three packed lines (bin_stall stays high), then takes one beat per cycle
// while pixels are not stalled. The centering register at address 0 may be
// written at any time the block is idle, including during that clear.
module waterfall_average_colormap (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	// bin channel
	input  logic                          bin_valid,
	output logic                          bin_stall,
	input  logic [wfac_pkg::IDX_W-1:0]    bin_index,
	input  logic [wfac_pkg::LEVEL_W-1:0]  bin_level,
	// pixel channel
	output logic                          pix_valid,
	input  logic                          pix_stall,
	output logic [wfac_pkg::COL_W-1:0]    pixel_column,
	output logic [wfac_pkg::CHAN_W-1:0]   red,
	output logic [wfac_pkg::CHAN_W-1:0]   green,
	output logic [wfac_pkg::CHAN_W-1:0]   blue
);

	import wfac_pkg::*;

	logic                 center_q;
	logic                 cfg_wr;
	logic                 clr_busy_q;
	logic [STORE_AW-1:0]  clr_addr_q;
	logic                 accept;
	logic [LINE_W-1:0]    idx_mod;
	logic [LINE_W-1:0]    rot_sum;
	logic [LINE_W-1:0]    col_full;
	logic [COL_W-1:0]     col_in;
	logic                 s1_valid_q;
	logic [COL_W-1:0]     col_s1;
	logic [LEVEL_W-1:0]   level_s1;
	logic                 s1_adv;
	logic [HIST_W-1:0]    ram_rdata;
	logic [HIST_W-1:0]    hist;
	logic [HIST_W-1:0]    hist_new;
	logic                 wr_valid_q;
	logic [COL_W-1:0]     wr_col_q;
	logic [HIST_W-1:0]    wr_data_q;
	logic [LEVEL_W+1:0]   level_sum;
	logic [LEVEL_W-1:0]   avg;
	logic                 ram_we;
	logic [STORE_AW-1:0]  ram_waddr;
	logic [HIST_W-1:0]    ram_wdata;
	logic                 pix_valid_q;
	logic [COL_W-1:0]     pixel_column_q;
	logic [CHAN_W-1:0]    red_q;
	logic [CHAN_W-1:0]    green_q;
	logic [CHAN_W-1:0]    blue_q;

	// Configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_CENTER) ? {31'b0, center_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= 1'b1;
		end else if (cfg_wr && paddr[2] == REG_CENTER) begin
			center_q <= pwdata[0];
		end
	end

	// Sweep the history RAM to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + STORE_AW'(1);
			if (clr_addr_q == STORE_AW'(STORE_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Handshake: take a beat when stage 1 is free or moving on and the clear is done
	assign s1_adv    = s1_valid_q && (!pix_valid_q || !pix_stall);
	assign bin_stall = clr_busy_q || (s1_valid_q && !s1_adv);
	assign accept    = bin_valid && !bin_stall;

	// Column placement with optional half-line rotation
	always_comb begin
		idx_mod  = LINE_W'(bin_index) % LINE_W'(LINE_BINS);
		rot_sum  = idx_mod + LINE_W'(HALF_ROT);
		col_full = idx_mod;
		if (center_q) begin
			col_full = (rot_sum >= LINE_W'(LINE_BINS)) ? rot_sum - LINE_W'(LINE_BINS)
				: rot_sum;
		end
		col_in = col_full[COL_W-1:0];
	end

	// Stage 1 holds the beat while its history is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1   <= col_in;
			level_s1 <= bin_level;
		end
	end

	// Bypass the write that landed on the same edge as our read
	assign hist     = (wr_valid_q && wr_col_q == col_s1) ? wr_data_q : ram_rdata;
	assign hist_new = {hist[2*LEVEL_W-1:LEVEL_W], hist[LEVEL_W-1:0], level_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_q <= 1'b0;
		end else if (s1_adv) begin
			wr_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			wr_col_q  <= col_s1;
			wr_data_q <= hist_new;
		end
	end

	// History RAM: previous, second and third lines packed per column
	assign ram_we    = clr_busy_q || s1_adv;
	assign ram_waddr = clr_busy_q ? clr_addr_q : STORE_AW'(col_s1);
	assign ram_wdata = clr_busy_q ? '0 : hist_new;

	wfac_ram #(
		.WIDTH(HIST_W),
		.DEPTH(STORE_DEPTH)
	) u_hist_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(STORE_AW'(col_in)),
		.rdata(ram_rdata)
	);

	// Average four lines, truncate and clamp
	always_comb begin
		level_sum = (LEVEL_W+2)'(level_s1) + (LEVEL_W+2)'(hist[LEVEL_W-1:0])
			+ (LEVEL_W+2)'(hist[2*LEVEL_W-1:LEVEL_W])
			+ (LEVEL_W+2)'(hist[3*LEVEL_W-1:2*LEVEL_W]);
		avg = level_sum[LEVEL_W+1:2];
		if (avg > LEVEL_CLAMP) begin
			avg = LEVEL_CLAMP;
		end
	end

	// Output register: load on advance, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (s1_adv) begin
			pix_valid_q <= 1'b1;
		end else if (!pix_stall) begin
			pix_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			pixel_column_q <= col_s1;
			red_q          <= pal_chan(avg, RED_OFFSET);
			green_q        <= pal_chan(avg, GREEN_OFFSET);
			blue_q         <= pal_chan(avg, BLUE_OFFSET);
		end
	end

	assign pix_valid    = pix_valid_q;
	assign pixel_column = pixel_column_q;
	assign red          = red_q;
	assign green        = green_q;
	assign blue         = blue_q;

endmodule
